// ----- rtl/core/pixel_range_offset_encoder_unit_defines.svh -----
// Assertion macros for the pixel range offset encoder.
// Used by the top level only; they rely on the clock and reset ports.
`ifndef PIXEL_RANGE_OFFSET_ENCODER_UNIT_DEFINES_SVH
`define PIXEL_RANGE_OFFSET_ENCODER_UNIT_DEFINES_SVH

// Checked while out of reset
`define PROE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked on every edge, reset included
`define PROE_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ----- rtl/core/proe_pkg.sv -----
// Shared types and constants for the pixel range offset encoder.
// No dependencies.
`default_nettype none

package proe_pkg;

   localparam int PIXEL_COUNT    = 65536;
   localparam int INDEX_WIDTH    = 16;
   localparam int CHANNELS       = 3;
   localparam int BYTE_WIDTH     = 8;
   localparam int RANGE_WIDTH    = CHANNELS * BYTE_WIDTH;
   localparam int REQ_DATA_WIDTH = INDEX_WIDTH + RANGE_WIDTH;
   localparam int REQ_USER_WIDTH = 2;
   localparam int RSP_DATA_WIDTH = RANGE_WIDTH;

   // Code emitted when the pixel sits on the range maximum and not on its minimum
   localparam logic [BYTE_WIDTH-1:0] CODE_AT_MAX = 8'h80;

   typedef enum logic {
      OP_ACCUMULATE = 1'b0,
      OP_ENCODE     = 1'b1
   } op_type;

endpackage

`default_nettype wire

// ----- rtl/core/proe_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module proe_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, old data on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/pixel_range_offset_encoder_unit.sv -----
// Pixel range offset encoder: per-pixel min/max store and offset coding.
// Depends on proe_pkg, proe_ram and pixel_range_offset_encoder_unit_defines.svh.
//
// Usage:
//   req channel carries one beat per pixel. tuser selects accumulate or encode
//   and flags the first frame of a group; tdata holds the pixel index and the
//   blue, green and red bytes. Accumulate beats update the stored range of
//   that pixel and give no result. Encode beats give one rsp beat holding the
//   three signed offset codes.
//   An encode beat goes through range read and merge, offset subtract and code
//   select, each stage registered, before it shows on rsp.
//   Throughput: one beat per cycle unless rsp stalls; range RAMs take one read
//   and one write per cycle, and a same-pixel update still in flight is forwarded.
//   Reset clears all pipeline valid bits; range contents are undefined until
//   a first-frame accumulate writes them.
//   When rsp_tready is low with a result waiting, the whole pipeline holds and
//   req_tready drops in the same cycle; nothing is lost or repeated.
`default_nettype none
`include "pixel_range_offset_encoder_unit_defines.svh"

module pixel_range_offset_encoder_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // pixel_index, blue_in, green_in, red_in
   input  wire logic [proe_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   // op, first_frame
   input  wire logic [proe_pkg::REQ_USER_WIDTH-1:0] req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // blue_code, green_code, red_code
   output logic      [proe_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata
);

   import proe_pkg::*;

   // pipeline enable
   logic advance;

   // stage 1: range read in flight
   logic                   s1_valid_ff, s1_valid_in;
   op_type                 s1_op_ff;
   logic                   s1_first_ff;
   logic [INDEX_WIDTH-1:0] s1_index_ff;
   logic [RANGE_WIDTH-1:0] s1_pixel_ff;
   logic [RANGE_WIDTH-1:0] ram_low_rd, ram_high_rd;

   // stage 1 merge
   logic                   fwd_hit;
   logic [RANGE_WIDTH-1:0] old_low, old_high;
   logic [RANGE_WIDTH-1:0] new_low, new_high;
   logic                   ram_wr_en;

   // stage 2: merged range
   logic                   s2_valid_ff;
   op_type                 s2_op_ff;
   logic [INDEX_WIDTH-1:0] s2_index_ff;
   logic [RANGE_WIDTH-1:0] s2_pixel_ff;
   logic [RANGE_WIDTH-1:0] s2_low_ff, s2_high_ff;
   logic [RANGE_WIDTH-1:0] down_in, up_in;

   // stage 3: offsets
   logic                   s3_valid_ff, s3_valid_in;
   logic [RANGE_WIDTH-1:0] s3_down_ff, s3_up_ff;

   // output register
   logic                   out_valid_ff;
   logic [RANGE_WIDTH-1:0] out_code_ff, out_code_in;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign s1_valid_in = req_tvalid && req_tready;

   // range stores, read as the beat enters stage 1
   proe_ram #(
      .WIDTH (RANGE_WIDTH),
      .DEPTH (PIXEL_COUNT)
   ) u_low_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (s1_index_ff),
      .wr_data (new_low),
      .rd_en   (advance),
      .rd_addr (req_tdata[INDEX_WIDTH-1:0]),
      .rd_data (ram_low_rd)
   );

   proe_ram #(
      .WIDTH (RANGE_WIDTH),
      .DEPTH (PIXEL_COUNT)
   ) u_high_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (s1_index_ff),
      .wr_data (new_high),
      .rd_en   (advance),
      .rd_addr (req_tdata[INDEX_WIDTH-1:0]),
      .rd_data (ram_high_rd)
   );

   // stage 1 registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_op_ff    <= op_type'(req_tuser[0]);
         s1_first_ff <= req_tuser[1];
         s1_index_ff <= req_tdata[INDEX_WIDTH-1:0];
         s1_pixel_ff <= req_tdata[REQ_DATA_WIDTH-1:INDEX_WIDTH];
      end
   end

   // the beat just ahead wrote at the same edge this one read: forward it
   assign fwd_hit  = s2_valid_ff && (s2_index_ff == s1_index_ff);
   assign old_low  = fwd_hit ? s2_low_ff  : ram_low_rd;
   assign old_high = fwd_hit ? s2_high_ff : ram_high_rd;

   // per-channel range update
   always_comb begin
      logic [BYTE_WIDTH-1:0] pix, lo, hi;
      new_low  = old_low;
      new_high = old_high;
      for (int c = 0; c < CHANNELS; c++) begin
         pix = s1_pixel_ff[c*BYTE_WIDTH +: BYTE_WIDTH];
         lo  = old_low[c*BYTE_WIDTH +: BYTE_WIDTH];
         hi  = old_high[c*BYTE_WIDTH +: BYTE_WIDTH];
         if (s1_op_ff == OP_ACCUMULATE) begin
            if (s1_first_ff) begin
               lo = pix;
               hi = pix;
            end else begin
               if (pix < lo) lo = pix;
               if (pix > hi) hi = pix;
            end
         end
         new_low[c*BYTE_WIDTH +: BYTE_WIDTH]  = lo;
         new_high[c*BYTE_WIDTH +: BYTE_WIDTH] = hi;
      end
   end

   assign ram_wr_en = advance && s1_valid_ff && (s1_op_ff == OP_ACCUMULATE);

   // stage 2 registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_op_ff    <= s1_op_ff;
         s2_index_ff <= s1_index_ff;
         s2_pixel_ff <= s1_pixel_ff;
         s2_low_ff   <= new_low;
         s2_high_ff  <= new_high;
      end
   end

   // offsets, wrapping in 8 bits
   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         down_in[c*BYTE_WIDTH +: BYTE_WIDTH] = s2_pixel_ff[c*BYTE_WIDTH +: BYTE_WIDTH]
                                             - s2_low_ff[c*BYTE_WIDTH +: BYTE_WIDTH];
         up_in[c*BYTE_WIDTH +: BYTE_WIDTH]   = s2_high_ff[c*BYTE_WIDTH +: BYTE_WIDTH]
                                             - s2_pixel_ff[c*BYTE_WIDTH +: BYTE_WIDTH];
      end
   end

   // only encode beats go on past stage 2
   assign s3_valid_in = s2_valid_ff && (s2_op_ff == OP_ENCODE);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_down_ff <= down_in;
         s3_up_ff   <= up_in;
      end
   end

   // code select
   always_comb begin
      logic [BYTE_WIDTH-1:0] dn, up;
      for (int c = 0; c < CHANNELS; c++) begin
         dn = s3_down_ff[c*BYTE_WIDTH +: BYTE_WIDTH];
         up = s3_up_ff[c*BYTE_WIDTH +: BYTE_WIDTH];
         priority if (up >= dn) begin
            out_code_in[c*BYTE_WIDTH +: BYTE_WIDTH] = dn;
         end else if (up == '0) begin
            out_code_in[c*BYTE_WIDTH +: BYTE_WIDTH] = CODE_AT_MAX;
         end else begin
            out_code_in[c*BYTE_WIDTH +: BYTE_WIDTH] = -up;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_code_ff <= out_code_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_code_ff;

   // checks
   `PROE_ASSERT_ALWAYS(a_reset_empties, reset |=> !s1_valid_ff && !s2_valid_ff && !s3_valid_ff && !rsp_tvalid, "pipeline not empty after reset")
   `PROE_ASSERT(a_stall_freezes, !advance |=> $stable(s1_valid_ff) && $stable(s2_valid_ff) && $stable(s3_valid_ff), "pipeline moved while stalled")
   `PROE_ASSERT(a_result_source, $rose(rsp_tvalid) |-> $past(s3_valid_ff), "result without an encode beat behind it")

endmodule

`default_nettype wire
